FILE: design/uol_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the unique ordered list engine
// no dependencies

package uol_pkg;

    localparam int DEPTH_DEF = 16;

    // request codes
    typedef enum logic [1:0] {
        REQ_APPEND  = 2'd0,
        REQ_REPLACE = 2'd1,
        REQ_DELETE  = 2'd2,
        REQ_LOCATE  = 2'd3
    } t_req;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_DUP      = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    // which end of the list a located entry is nearer to
    typedef enum logic [1:0] {
        NEAR_EQUAL = 2'd0,
        NEAR_TAIL  = 2'd1,
        NEAR_HEAD  = 2'd2
    } t_nearer;

    // control sequence
    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_COMMIT
    } t_state;

    // update applied to every cell of the chain
    typedef enum logic [1:0] {
        OP_NONE,
        OP_WR_TAIL,
        OP_WR_HIT,
        OP_SHIFT
    } t_cell_op;

    typedef struct packed {
        t_cell_op    op;
        logic [31:0] data;
    } t_cell_cmd;

endpackage

FILE: design/uol_cell.sv
`timescale 1ns / 1ps
// one list slot: holds a value, compares it with the request, takes updates
// depends on uol_pkg

module uol_cell
    import uol_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int IDX   = 0,
    localparam int CntW = $clog2(DEPTH + 1),
    localparam int PosW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic            i_clk,
    input  logic            i_cmp_en,
    input  logic [CntW-1:0] i_count,
    input  logic [PosW-1:0] i_pos,
    input  logic [31:0]     i_key,
    input  logic [31:0]     i_new,
    input  t_cell_cmd       i_cmd,
    input  logic [31:0]     i_next_value,
    output logic [31:0]     o_value,
    output logic            o_hit_key,
    output logic            o_hit_new
);

    localparam logic [CntW-1:0] MyIdx = CntW'(IDX);
    localparam logic [PosW-1:0] MyPos = PosW'(IDX);

    logic [31:0] r_value;
    logic [31:0] n_value;
    logic        r_hit_key;
    logic        r_hit_new;
    logic        occ;

    // slot holds a live entry
    assign occ = (MyIdx < i_count);

    // next value from the broadcast command
    always_comb begin
        n_value = r_value;
        case (i_cmd.op)
            OP_WR_TAIL: begin
                if (i_count == MyIdx) n_value = i_cmd.data;
            end
            OP_WR_HIT: begin
                if (r_hit_key) n_value = i_cmd.data;
            end
            OP_SHIFT: begin
                if (MyPos >= i_pos) n_value = i_next_value;
            end
            default: n_value = r_value;
        endcase
    end

    // value storage and registered match flags
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        if (i_cmp_en) begin
            r_hit_key <= occ && (r_value == i_key);
            r_hit_new <= occ && (r_value == i_new);
        end
    end

    assign o_value   = r_value;
    assign o_hit_key = r_hit_key;
    assign o_hit_new = r_hit_new;

endmodule

FILE: design/uol_chain.sv
`timescale 1ns / 1ps
// row of list cells, each linked to its tail-side neighbour for deletes
// depends on uol_pkg and uol_cell

module uol_chain
    import uol_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    localparam int CntW = $clog2(DEPTH + 1),
    localparam int PosW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_cmp_en,
    input  logic [CntW-1:0]  i_count,
    input  logic [PosW-1:0]  i_pos,
    input  logic [31:0]      i_key,
    input  logic [31:0]      i_new,
    input  t_cell_cmd        i_cmd,
    output logic [DEPTH-1:0] o_hit_key,
    output logic [DEPTH-1:0] o_hit_new
);

    logic [31:0] values [DEPTH];

    // cells, each but the last pulling from its tail-side neighbour on a shift
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [31:0] next_value;
        if (g < DEPTH - 1) begin : g_link
            assign next_value = values[g + 1];
        end else begin : g_last
            assign next_value = values[g];
        end

        uol_cell #(
            .DEPTH (DEPTH),
            .IDX   (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_cmp_en     (i_cmp_en),
            .i_count      (i_count),
            .i_pos        (i_pos),
            .i_key        (i_key),
            .i_new        (i_new),
            .i_cmd        (i_cmd),
            .i_next_value (next_value),
            .o_value      (values[g]),
            .o_hit_key    (o_hit_key[g]),
            .o_hit_new    (o_hit_new[g])
        );
    end

endmodule

FILE: design/unique_ordered_list_engine.sv
`timescale 1ns / 1ps
// unique ordered list engine: one request in, one result out
// each request passes the compare step in the cells, then the commit step, which waits
// while an untaken result holds the output; a new request enters at commit or when idle
// the output register lets the next request enter while a result waits
// synchronous active-low reset empties the list; stored values are not cleared
// depends on uol_pkg and uol_chain

module unique_ordered_list_engine
    import uol_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    localparam int CntW = $clog2(DEPTH + 1),
    localparam int PosW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_req_type,
    input  logic signed [31:0] i_key_value,
    input  logic signed [31:0] i_new_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [2:0]         o_status,
    output logic [1:0]         o_nearer_end,
    output logic [3:0]         o_found_position,
    output logic [4:0]         o_entry_count
);

    t_state          r_state, n_state;
    t_req            r_req;
    logic [31:0]     r_key;
    logic [31:0]     r_new;
    logic [CntW-1:0] r_count, n_count;
    logic            r_out_valid;
    t_status         r_status, n_status;
    t_nearer         r_nearer, n_nearer;
    logic [PosW-1:0] r_pos_out;

    logic [DEPTH-1:0] hit_key;
    logic [DEPTH-1:0] hit_new;
    logic [PosW-1:0]  pos;
    logic             any_key;
    logic             any_new;
    logic             commit_go;
    logic             in_acc;
    logic             cmp_en;
    t_cell_cmd        cmd;
    logic [CntW-1:0]  from_tail;
    logic [CntW-1:0]  pos_cnt;
    logic [PosW+3:0]  pos_ext;
    logic [CntW+4:0]  cnt_ext;

    // commit may proceed when the output slot is free or being emptied
    assign commit_go  = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) || (r_state == S_COMMIT && commit_go);
    assign in_acc     = i_in_valid && o_in_ready;
    assign cmp_en     = (r_state == S_CMP);

    // request registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req <= t_req'(i_req_type);
            r_key <= i_key_value;
            r_new <= i_new_value;
        end
    end

    // cell chain
    uol_chain #(
        .DEPTH (DEPTH)
    ) u_chain (
        .i_clk     (i_clk),
        .i_cmp_en  (cmp_en),
        .i_count   (r_count),
        .i_pos     (pos),
        .i_key     (r_key),
        .i_new     (r_new),
        .i_cmd     (cmd),
        .o_hit_key (hit_key),
        .o_hit_new (hit_new)
    );

    // position of the matching cell; at most one cell matches
    always_comb begin
        pos = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (hit_key[i]) pos = pos | PosW'(i);
        end
    end

    assign any_key   = |hit_key;
    assign any_new   = |hit_new;
    assign pos_cnt   = CntW'(pos);
    assign from_tail = r_count - CntW'(1) - pos_cnt;

    // commit decode: status, count update and cell command
    always_comb begin
        n_status = ST_OK;
        n_nearer = NEAR_EQUAL;
        n_count  = r_count;
        cmd.op   = OP_NONE;
        cmd.data = r_key;
        if (r_req == REQ_APPEND) begin
            if (any_key) begin
                n_status = ST_DUP;
            end else if (r_count >= CntW'(DEPTH)) begin
                n_status = ST_FULL;
            end else begin
                cmd.op  = OP_WR_TAIL;
                n_count = r_count + CntW'(1);
            end
        end else if (r_count == '0) begin
            n_status = ST_EMPTY;
        end else if (!any_key) begin
            n_status = ST_NOTFOUND;
        end else begin
            case (r_req)
                REQ_REPLACE: begin
                    if (any_new) begin
                        n_status = ST_DUP;
                    end else begin
                        cmd.op   = OP_WR_HIT;
                        cmd.data = r_new;
                    end
                end
                REQ_DELETE: begin
                    cmd.op  = OP_SHIFT;
                    n_count = r_count - CntW'(1);
                end
                REQ_LOCATE: begin
                    if (from_tail == pos_cnt) n_nearer = NEAR_EQUAL;
                    else if (from_tail < pos_cnt) n_nearer = NEAR_TAIL;
                    else n_nearer = NEAR_HEAD;
                end
                default: n_status = ST_OK;
            endcase
        end
        if (!(r_state == S_COMMIT && commit_go)) begin
            cmd.op  = OP_NONE;
            n_count = r_count;
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) n_state = S_CMP;
            end
            S_CMP: n_state = S_COMMIT;
            S_COMMIT: begin
                if (commit_go) n_state = in_acc ? S_CMP : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // entry count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (r_state == S_COMMIT && commit_go) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    // result payload; an append never reports a position
    always_ff @(posedge i_clk) begin
        if (r_state == S_COMMIT && commit_go) begin
            r_status  <= n_status;
            r_nearer  <= n_nearer;
            r_pos_out <= (r_req == REQ_APPEND) ? '0 : pos;
        end
    end

    assign pos_ext = {4'b0, r_pos_out};
    assign cnt_ext = {5'b0, r_count};

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_nearer_end     = r_nearer;
    assign o_found_position = pos_ext[3:0];
    assign o_entry_count    = cnt_ext[4:0];

    // checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(DEPTH))
        else $error("entry count beyond depth");

    a_hit_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_COMMIT |-> $onehot0(hit_key) && $onehot0(hit_new))
        else $error("more than one cell matched");

    a_delete_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMMIT && commit_go && r_req == REQ_DELETE && n_status == ST_OK)
        |=> r_count == $past(r_count) - CntW'(1))
        else $error("delete did not shrink the list");

    a_accept_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state == S_CMP)
        else $error("accepted request not compared");

endmodule

FILE: tb/tb_unique_ordered_list_engine.sv
`timescale 1ns / 1ps
// self-checking bench for the unique ordered list engine: directed corner requests,
// then random request sequences with random idling on both handshakes
// depends on uol_pkg and the unique_ordered_list_engine rtl

module tb_unique_ordered_list_engine;
    import uol_pkg::*;

    localparam int LIST_DEPTH  = DEPTH_DEF;
    localparam int POOL_SIZE   = 24;
    localparam int RANDOM_REQS = 950;
    localparam int CYCLE_LIMIT = 100000;

    // one result as the block should present it
    typedef struct {
        t_status    status;
        t_nearer    nearer;
        logic [3:0] position;
        logic [4:0] count;
    } t_list_outcome;

    // mirror of the stored list plus the queue of outcomes still owed
    class ordered_list_tracker;
        logic [31:0]   slot_values[LIST_DEPTH];
        int            fill_level;
        t_list_outcome pending_outcomes[$];
        int            mismatch_count;
        int            result_index;

        function new();
            fill_level     = 0;
            mismatch_count = 0;
            result_index   = 0;
        endfunction

        function automatic int find_slot(logic [31:0] value);
            for (int i = 0; i < fill_level; i++) begin
                if (slot_values[i] == value) return i;
            end
            return -1;
        endfunction

        task flag_mismatch(string what);
            $display("ERROR result %0d at %0t: %s", result_index, $realtime, what);
            mismatch_count++;
        endtask

        // apply an accepted request to the mirror and queue its outcome
        function automatic void note_request(t_req req, logic [31:0] key,
                                             logic [31:0] repl);
            t_list_outcome want;
            int            hit;
            int            tail_dist;
            want.status   = ST_OK;
            want.nearer   = NEAR_EQUAL;
            want.position = '0;
            hit = find_slot(key);
            if (req == REQ_APPEND) begin
                // duplicate check takes priority over the full check
                if (hit >= 0) begin
                    want.status = ST_DUP;
                end else if (fill_level >= LIST_DEPTH) begin
                    want.status = ST_FULL;
                end else begin
                    slot_values[fill_level] = key;
                    fill_level++;
                end
            end else if (fill_level == 0) begin
                want.status = ST_EMPTY;
            end else if (hit < 0) begin
                want.status = ST_NOTFOUND;
            end else begin
                want.position = 4'(hit);
                case (req)
                    REQ_REPLACE: begin
                        if (find_slot(repl) >= 0) want.status = ST_DUP;
                        else slot_values[hit] = repl;
                    end
                    REQ_DELETE: begin
                        // close the gap towards the head
                        for (int i = hit; i + 1 < fill_level; i++)
                            slot_values[i] = slot_values[i + 1];
                        fill_level--;
                    end
                    default: begin
                        tail_dist = fill_level - 1 - hit;
                        if (tail_dist == hit) want.nearer = NEAR_EQUAL;
                        else if (tail_dist < hit) want.nearer = NEAR_TAIL;
                        else want.nearer = NEAR_HEAD;
                    end
                endcase
            end
            want.count = 5'(fill_level);
            pending_outcomes.push_back(want);
        endfunction

        // compare one accepted result against the oldest owed outcome
        task check_result(logic [2:0] status, logic [1:0] nearer,
                          logic [3:0] position, logic [4:0] count);
            t_list_outcome want;
            if (pending_outcomes.size() == 0) begin
                flag_mismatch($sformatf("result with nothing owed, status %0d", status));
                result_index++;
                return;
            end
            want = pending_outcomes.pop_front();
            if (status !== want.status)
                flag_mismatch($sformatf("status got %0d want %0d", status, want.status));
            if (nearer !== want.nearer)
                flag_mismatch($sformatf("nearer_end got %0d want %0d", nearer, want.nearer));
            if (position !== want.position)
                flag_mismatch($sformatf("found_position got %0d want %0d",
                                        position, want.position));
            if (count !== want.count)
                flag_mismatch($sformatf("entry_count got %0d want %0d", count, want.count));
            result_index++;
        endtask
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         req_type;
    logic signed [31:0] key_value;
    logic signed [31:0] new_value;
    logic               out_valid;
    logic               out_ready;
    logic [2:0]         status;
    logic [1:0]         nearer_end;
    logic [3:0]         found_position;
    logic [4:0]         entry_count;

    ordered_list_tracker tracker = new();
    logic [31:0]         value_pool[POOL_SIZE];
    bit                  no_idle;
    int                  cycle_count;

    unique_ordered_list_engine u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_req_type       (req_type),
        .i_key_value      (key_value),
        .i_new_value      (new_value),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_status         (status),
        .o_nearer_end     (nearer_end),
        .o_found_position (found_position),
        .o_entry_count    (entry_count)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // drive one request, called at a falling edge, returns at a falling edge
    task send_request(input t_req req, input logic [31:0] key, input logic [31:0] repl);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid  = 1'b1;
        req_type  = req;
        key_value = key;
        new_value = repl;
        do @(posedge i_clk); while (!in_ready);
        tracker.note_request(req, key, repl);
        @(negedge i_clk);
    endtask

    // mostly stored or pooled values so hits and duplicates are common
    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5 && tracker.fill_level > 0)
            return tracker.slot_values[$urandom_range(0, tracker.fill_level - 1)];
        if (r < 9) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom();
    endfunction

    // result side: random stalls per result, sampled at the rising edge
    initial begin
        int stall;
        out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                out_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ready = 1'b1;
            do @(posedge i_clk); while (!out_valid);
            tracker.check_result(status, nearer_end, found_position, entry_count);
            @(negedge i_clk);
        end
    end

    // run limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // stimulus and end of run
    initial begin
        int   sent;
        int   mode;
        int   run_len;
        int   pick;
        t_req req;
        logic [31:0] repl;

        i_rst_n   = 1'b0;
        in_valid  = 1'b0;
        req_type  = REQ_APPEND;
        key_value = '0;
        new_value = '0;
        no_idle   = 1'b0;
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7fff_ffff;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hffff_ffff;
        for (int i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom();
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // requests on an empty list
        send_request(REQ_LOCATE, 32'd5, 32'd0);
        send_request(REQ_DELETE, 32'd5, 32'd0);
        send_request(REQ_REPLACE, 32'd5, 32'd6);
        // deleting the sole entry empties the list
        send_request(REQ_APPEND, 32'h8000_0000, 32'hffff_ffff);
        send_request(REQ_DELETE, 32'h8000_0000, 32'd0);
        send_request(REQ_LOCATE, 32'h8000_0000, 32'd0);
        // extremes, then a duplicate append
        send_request(REQ_APPEND, 32'h8000_0000, 32'd0);
        send_request(REQ_APPEND, 32'h7fff_ffff, 32'd0);
        send_request(REQ_APPEND, 32'h0000_0000, 32'd0);
        send_request(REQ_APPEND, 32'h7fff_ffff, 32'd0);
        // locate at middle, head, tail and a missing value
        send_request(REQ_LOCATE, 32'h7fff_ffff, 32'd0);
        send_request(REQ_LOCATE, 32'h8000_0000, 32'd0);
        send_request(REQ_LOCATE, 32'h0000_0000, 32'd0);
        send_request(REQ_LOCATE, 32'd12345, 32'd0);
        // replace onto itself, onto another stored value, a good one, then a missing key
        send_request(REQ_REPLACE, 32'h0000_0000, 32'h0000_0000);
        send_request(REQ_REPLACE, 32'h0000_0000, 32'h8000_0000);
        send_request(REQ_REPLACE, 32'h0000_0000, 32'hffff_ffff);
        send_request(REQ_REPLACE, 32'd99, 32'd7);
        // delete in the middle and a missing value, then locate the moved tail
        send_request(REQ_DELETE, 32'h7fff_ffff, 32'd0);
        send_request(REQ_DELETE, 32'd99, 32'd0);
        send_request(REQ_LOCATE, 32'hffff_ffff, 32'd0);

        // random runs: grow, shrink, mixed and raw-noise phases
        sent = 0;
        while (sent < RANDOM_REQS) begin
            mode    = $urandom_range(0, 3);
            run_len = $urandom_range(20, 60);
            no_idle = ($urandom_range(0, 4) == 0);
            repeat (run_len) begin
                pick = $urandom_range(0, 9);
                case (mode)
                    0: req = (pick < 7) ? REQ_APPEND : t_req'($urandom_range(1, 3));
                    1: req = (pick < 6) ? REQ_DELETE : t_req'($urandom_range(0, 3));
                    default: req = t_req'($urandom_range(0, 3));
                endcase
                if (mode == 3) begin
                    send_request(req, $urandom(), $urandom());
                end else begin
                    repl = (req == REQ_REPLACE) ? pick_value() : $urandom();
                    send_request(req, pick_value(), repl);
                end
                sent++;
            end
        end
        in_valid = 1'b0;

        // drain, then keep watching to catch stray results
        while (tracker.pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (tracker.mismatch_count == 0 && tracker.pending_outcomes.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: filelist.f
design/uol_pkg.sv
design/uol_cell.sv
design/uol_chain.sv
design/unique_ordered_list_engine.sv
tb/tb_unique_ordered_list_engine.sv
